// ===== src/hmq_pkg.sv =====
// Package for the binary max-heap queue core.
// Holds field widths, command and status codes, and the request and result types.
// No dependencies.
`default_nettype none
package hmq_pkg;

  localparam int HMQ_CAPACITY      = 64;
  localparam int HMQ_PAYLOAD_WIDTH = 16;
  localparam int HMQ_KEY_W         = 32;
  localparam int HMQ_PAY_FIELD_W   = 16;
  localparam int HMQ_COUNT_FIELD_W = 7;

  typedef enum logic {
    HMQ_PUSH = 1'b0,
    HMQ_POP  = 1'b1
  } hmq_cmd_e;

  typedef enum logic [1:0] {
    HMQ_ST_DONE  = 2'd0,
    HMQ_ST_EMPTY = 2'd1,
    HMQ_ST_FULL  = 2'd2
  } hmq_status_e;

  typedef struct packed {
    hmq_cmd_e                     cmd;
    logic signed [HMQ_KEY_W-1:0]  key;
    logic [HMQ_PAY_FIELD_W-1:0]   payload;
  } hmq_in_t;

  typedef struct packed {
    logic [HMQ_PAY_FIELD_W-1:0]   out_payload;
    logic signed [HMQ_KEY_W-1:0]  out_key;
    hmq_status_e                  status;
    logic [HMQ_COUNT_FIELD_W-1:0] count;
  } hmq_out_t;

endpackage
`default_nettype wire

// ===== src/hmq_mem.sv =====
// Entry memory of the heap: one write port, two read ports, registered read data.
// Standalone; holds key and payload of each slot packed in one word.
`default_nettype none
module hmq_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 48,
  parameter int AW    = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_a_i,
  input  wire logic [AW-1:0]    raddr_b_i,
  output logic      [WIDTH-1:0] rdata_a_o,
  output logic      [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule
`default_nettype wire

// ===== src/hmq_ctrl.sv =====
// Sequencer of the heap queue: push sift-up, pop hole walk and refill sift-up.
// Drives the entry memory ports; uses hmq_pkg for request and result types.
`default_nettype none
module hmq_ctrl #(
  parameter int CAPACITY      = 64,
  parameter int PAYLOAD_WIDTH = 16,
  parameter int AW            = 6,
  parameter int CW            = 7,
  parameter int EW            = 48
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire hmq_pkg::hmq_in_t req_i,
  output logic                  done_o,
  output hmq_pkg::hmq_out_t     res_o,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [EW-1:0]         mem_wdata_o,
  output logic [AW-1:0]         mem_raddr_a_o,
  output logic [AW-1:0]         mem_raddr_b_o,
  input  wire logic [EW-1:0]    mem_rdata_a_i,
  input  wire logic [EW-1:0]    mem_rdata_b_i
);
  import hmq_pkg::*;

  localparam int XW = AW + 2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SIFT  = 6'b000010,
    S_PLACE = 6'b000100,
    S_ROOT  = 6'b001000,
    S_WALK  = 6'b010000,
    S_SUPRD = 6'b100000
  } state_e;

  state_e                    state_q, state_d;
  logic signed [HMQ_KEY_W-1:0] key_q, key_d;
  logic [PAYLOAD_WIDTH-1:0]  pay_q, pay_d;
  logic [AW-1:0]             pos_q, pos_d;
  logic [AW-1:0]             c_q, c_d;
  logic [AW-1:0]             hole_q, hole_d;
  logic [CW-1:0]             n_q, n_d;
  logic [CW-1:0]             count_q, count_d;
  hmq_out_t                  res_q, res_d;
  logic                      done_q, done_d;

  logic signed [HMQ_KEY_W-1:0] key_a, key_b;
  logic [PAYLOAD_WIDTH-1:0]    pay_a;
  logic [AW-1:0]               up;
  logic [CW-1:0]               cb;
  logic                        take_b;
  logic [AW-1:0]               sel;
  logic [AW:0]                 nc;
  logic [XW-1:0]               nc_x, ncb_x, n_x;
  logic [PAYLOAD_WIDTH+HMQ_PAY_FIELD_W-1:0] pay_in_ext, pay_out_ext;
  logic [CW+HMQ_COUNT_FIELD_W-1:0]          cnt_ext;

  assign key_a = $signed(mem_rdata_a_i[EW-1 -: HMQ_KEY_W]);
  assign key_b = $signed(mem_rdata_b_i[EW-1 -: HMQ_KEY_W]);
  assign pay_a = mem_rdata_a_i[PAYLOAD_WIDTH-1:0];
  assign up    = AW'((pos_q - AW'(1)) >> 1);
  assign cb    = CW'(c_q) + CW'(1);
  assign take_b = (cb < n_q) && (key_a < key_b);
  assign sel   = take_b ? cb[AW-1:0] : c_q;
  assign nc    = {sel, 1'b1};
  assign nc_x  = XW'(nc);
  assign ncb_x = nc_x + XW'(1);
  assign n_x   = XW'(n_q);

  assign pay_in_ext  = {{PAYLOAD_WIDTH{1'b0}}, req_i.payload};
  assign pay_out_ext = {{HMQ_PAY_FIELD_W{1'b0}}, pay_a};
  assign cnt_ext     = {{HMQ_COUNT_FIELD_W{1'b0}}, count_d};

  always_comb begin
    state_d       = state_q;
    key_d         = key_q;
    pay_d         = pay_q;
    pos_d         = pos_q;
    c_d           = c_q;
    hole_d        = hole_q;
    n_d           = n_q;
    count_d       = count_q;
    res_d         = res_q;
    done_d        = 1'b0;
    mem_we_o      = 1'b0;
    mem_waddr_o   = pos_q;
    mem_wdata_o   = {key_q, pay_q};
    mem_raddr_a_o = up;
    mem_raddr_b_o = up;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          key_d               = req_i.key;
          pay_d               = pay_in_ext[PAYLOAD_WIDTH-1:0];
          res_d.out_key       = '0;
          res_d.out_payload   = '0;
          res_d.status        = HMQ_ST_DONE;
          if (req_i.cmd == HMQ_PUSH) begin
            if (count_q == CW'(CAPACITY)) begin
              res_d.status = HMQ_ST_FULL;
              done_d       = 1'b1;
            end else if (count_q == '0) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = '0;
              mem_wdata_o = {req_i.key, pay_in_ext[PAYLOAD_WIDTH-1:0]};
              count_d     = count_q + CW'(1);
              done_d      = 1'b1;
            end else begin
              pos_d         = count_q[AW-1:0];
              mem_raddr_a_o = AW'((count_q[AW-1:0] - AW'(1)) >> 1);
              count_d       = count_q + CW'(1);
              state_d       = S_SIFT;
            end
          end else begin
            if (count_q == '0) begin
              res_d.status = HMQ_ST_EMPTY;
              done_d       = 1'b1;
            end else begin
              n_d           = count_q;
              mem_raddr_a_o = '0;
              mem_raddr_b_o = AW'(count_q - CW'(1));
              state_d       = S_ROOT;
            end
          end
        end
      end

      S_SIFT: begin
        mem_we_o = 1'b1;
        if (key_a > key_q) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          mem_wdata_o   = mem_rdata_a_i;
          pos_d         = up;
          mem_raddr_a_o = AW'((up - AW'(1)) >> 1);
          if (up == '0) begin
            state_d = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        mem_we_o = 1'b1;
        done_d   = 1'b1;
        state_d  = S_IDLE;
      end

      S_ROOT: begin
        res_d.out_key     = key_a;
        res_d.out_payload = pay_out_ext[HMQ_PAY_FIELD_W-1:0];
        key_d             = key_b;
        pay_d             = mem_rdata_b_i[PAYLOAD_WIDTH-1:0];
        count_d           = n_q - CW'(1);
        if (n_q == CW'(1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          c_d           = AW'(1);
          hole_d        = '0;
          mem_raddr_a_o = AW'(1);
          mem_raddr_b_o = (n_q > CW'(2)) ? AW'(2) : AW'(1);
          state_d       = S_WALK;
        end
      end

      S_WALK: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = hole_q;
        mem_wdata_o = take_b ? mem_rdata_b_i : mem_rdata_a_i;
        hole_d      = sel;
        if (nc_x < n_x) begin
          c_d           = nc[AW-1:0];
          mem_raddr_a_o = nc[AW-1:0];
          mem_raddr_b_o = (ncb_x < n_x) ? ncb_x[AW-1:0] : nc[AW-1:0];
        end else if (CW'(sel) == n_q - CW'(1)) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          pos_d   = sel;
          state_d = S_SUPRD;
        end
      end

      S_SUPRD: begin
        state_d = S_SIFT;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done_d) begin
      res_d.count = cnt_ext[HMQ_COUNT_FIELD_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    pay_q  <= pay_d;
    pos_q  <= pos_d;
    c_q    <= c_d;
    hole_q <= hole_d;
    n_q    <= n_d;
    res_q  <= res_d;
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule
`default_nettype wire

// ===== src/binary_max_heap_queue_core.sv =====
// Top level of the binary max-heap queue core.
// Instantiates hmq_ctrl and hmq_mem; uses hmq_pkg for request and result types.
//
// Usage:
//   Request channel: drive req_i and raise start; the command transfers at a
//   rising edge where start is high and busy is low. cmd selects push or pop.
//   Result channel: each command gives one result on res_o, marked by done_o
//   for exactly one cycle. The receiver cannot stall; take it in that cycle.
//   Every result reports the entry count after the command. A push on a full
//   queue is dropped with status full; a pop on an empty queue gives status
//   empty. Key and payload of a result are zero except for a real pop.
// Timing:
//   One entry memory level per cycle, bound by the memory's registered read
//   data and single write port. Status results and a push into an empty
//   queue finish straight from idle. A push sifts the new entry up level by
//   level. A pop reads the root and the last entry, then walks the hole down;
//   it ends there when the hole ends on the last entry, else it refills the
//   hole with the last entry and sifts it up. No command transfers while busy
//   is high; the next may transfer at the edge that ends the done_o cycle.
// Reset:
//   Clears the count and the sequencer; memory contents need no reset.
`default_nettype none
module binary_max_heap_queue_core #(
  parameter int CAPACITY      = hmq_pkg::HMQ_CAPACITY,
  parameter int PAYLOAD_WIDTH = hmq_pkg::HMQ_PAYLOAD_WIDTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire hmq_pkg::hmq_in_t req_i,
  output logic                  done_o,
  output hmq_pkg::hmq_out_t     res_o
);
  import hmq_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = HMQ_KEY_W + PAYLOAD_WIDTH;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr_a;
  logic [AW-1:0] mem_raddr_b;
  logic [EW-1:0] mem_rdata_a;
  logic [EW-1:0] mem_rdata_b;

  hmq_ctrl #(
    .CAPACITY      (CAPACITY),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .AW            (AW),
    .CW            (CW),
    .EW            (EW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_i         (req_i),
    .done_o        (done_o),
    .res_o         (res_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_a_o (mem_raddr_a),
    .mem_raddr_b_o (mem_raddr_b),
    .mem_rdata_a_i (mem_rdata_a),
    .mem_rdata_b_i (mem_rdata_b)
  );

  hmq_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (EW),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (mem_raddr_b),
    .rdata_a_o (mem_rdata_a),
    .rdata_b_o (mem_rdata_b)
  );

endmodule
`default_nettype wire

// ===== sim/tb_binary_max_heap_queue_core.sv =====
// Self-checking testbench for binary_max_heap_queue_core: push/pop traffic with
// random gaps, results scored against an in-bench max-heap predictor.
// Depends on hmq_pkg and the core RTL.
`timescale 1ns / 1ps
module tb_binary_max_heap_queue_core;
  import hmq_pkg::*;

  localparam int RANDOM_ITEMS   = 1800;
  localparam int DRAIN_CYCLES   = 40;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int REPORT_LIMIT   = 10;

  class heap_result_checker;
    logic signed [HMQ_KEY_W-1:0]       key_mem[HMQ_CAPACITY];
    logic [HMQ_PAY_FIELD_W-1:0]        pay_mem[HMQ_CAPACITY];
    int                                held;
    hmq_out_t                          expected_results[$];
    int                                mismatches;

    function new();
      held       = 0;
      mismatches = 0;
    endfunction

    function void place_rising(int pos, logic signed [HMQ_KEY_W-1:0] k,
                               logic [HMQ_PAY_FIELD_W-1:0] p);
      int parent;
      while (pos > 0) begin
        parent = (pos - 1) / 2;
        if (key_mem[parent] > k) break;
        key_mem[pos] = key_mem[parent];
        pay_mem[pos] = pay_mem[parent];
        pos = parent;
      end
      key_mem[pos] = k;
      pay_mem[pos] = p;
    endfunction

    function void note_transfer(hmq_in_t req);
      hmq_out_t                    res;
      int                          n;
      int                          hole;
      int                          c;
      logic signed [HMQ_KEY_W-1:0] last_key;
      logic [HMQ_PAY_FIELD_W-1:0]  last_pay;
      res        = '0;
      res.status = HMQ_ST_DONE;
      if (req.cmd == HMQ_PUSH) begin
        if (held >= HMQ_CAPACITY) begin
          res.status = HMQ_ST_FULL;
        end else begin
          held++;
          place_rising(held - 1, $signed(req.key), req.payload);
        end
      end else if (held == 0) begin
        res.status = HMQ_ST_EMPTY;
      end else begin
        n               = held;
        hole            = 0;
        res.out_payload = pay_mem[0];
        res.out_key     = key_mem[0];
        // lift the larger child along one path, left wins on ties
        for (c = 1; c < n; c = c * 2 + 1) begin
          if (c + 1 < n && key_mem[c] < key_mem[c + 1]) c++;
          key_mem[hole] = key_mem[c];
          pay_mem[hole] = pay_mem[c];
          hole = c;
        end
        held     = n - 1;
        last_key = key_mem[n - 1];
        last_pay = pay_mem[n - 1];
        if (hole != n - 1) place_rising(hole, last_key, last_pay);
      end
      res.count = HMQ_COUNT_FIELD_W'(held);
      expected_results.push_back(res);
    endfunction

    function void check_result(hmq_out_t got);
      hmq_out_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: payload %h key %0d status %0d count %0d",
                   got.out_payload, got.out_key, got.status, got.count);
        return;
      end
      want = expected_results.pop_front();
      if (got.out_payload !== want.out_payload || got.out_key !== want.out_key ||
          got.status !== want.status || got.count !== want.count) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"result mismatch: expected payload %h key %0d status %0d",
                    " count %0d, got payload %h key %0d status %0d count %0d"},
                   want.out_payload, want.out_key, want.status, want.count,
                   got.out_payload, got.out_key, got.status, got.count);
      end
    endfunction
  endclass

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  hmq_in_t  req_i;
  logic     done_o;
  hmq_out_t res_o;

  heap_result_checker heap_check = new();
  bit                 no_gaps;
  int                 cycles;

  binary_max_heap_queue_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("binary_max_heap_queue_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) heap_check.check_result(res_o);
      if (start && !busy) heap_check.note_transfer(req_i);
    end
  end

  task automatic send_item(input hmq_in_t item);
    int gap;
    req_i <= item;
    start <= 1'b1;
    @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
    gap = no_gaps ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_push(input logic signed [HMQ_KEY_W-1:0] k,
                           input logic [HMQ_PAY_FIELD_W-1:0] p);
    hmq_in_t item;
    item.cmd     = HMQ_PUSH;
    item.key     = k;
    item.payload = p;
    send_item(item);
  endtask

  task automatic send_pop();
    hmq_in_t item;
    item.cmd     = HMQ_POP;
    item.key     = $urandom;
    item.payload = HMQ_PAY_FIELD_W'($urandom);
    send_item(item);
  endtask

  function automatic logic signed [HMQ_KEY_W-1:0] random_key();
    int offset;
    logic signed [HMQ_KEY_W-1:0] k;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: k = $urandom;
      4, 5, 6: begin
        offset = $urandom_range(0, 16);
        k = offset - 8;
      end
      7: begin
        case ($urandom_range(0, 3))
          0: k = 32'sh7fffffff;
          1: k = 32'sh80000000;
          2: k = '0;
          default: k = '1;
        endcase
      end
      default: begin
        offset = $urandom_range(0, 2000);
        k = offset - 1000;
      end
    endcase
    return k;
  endfunction

  initial begin
    int sent;
    int phase_len;
    int push_pct;
    rst_ni  = 1'b0;
    start   = 1'b0;
    req_i   = '0;
    no_gaps = 1'b0;
    cycles  = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty pop, extreme keys and payloads, equal keys, drain past empty
    send_pop();
    send_push(32'sh7fffffff, 16'hffff);
    send_push(32'sh80000000, 16'h0000);
    send_push('0, 16'h5a5a);
    send_push('1, 16'ha5a5);
    send_push(32'sd5, 16'h0001);
    send_push(32'sd5, 16'h0002);
    send_push(32'sh7fffffff, 16'h8000);
    send_push(32'sd5, 16'h0003);
    repeat (10) send_pop();

    // random phases with a push bias each, so the heap fills and drains
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 160);
      no_gaps   = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0: push_pct = 15;
        1: push_pct = 50;
        2: push_pct = 70;
        default: push_pct = 95;
      endcase
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < push_pct)
          send_push(random_key(), HMQ_PAY_FIELD_W'($urandom));
        else send_pop();
        sent++;
      end
    end
    start <= 1'b0;

    while (heap_check.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (heap_check.mismatches == 0 && heap_check.expected_results.size() == 0) begin
      $display("binary_max_heap_queue_core regression: pass");
    end else begin
      $display("binary_max_heap_queue_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/hmq_pkg.sv
src/hmq_mem.sv
src/hmq_ctrl.sv
src/binary_max_heap_queue_core.sv
sim/tb_binary_max_heap_queue_core.sv
